// ----- sv/wsd_pkg.sv -----
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 1;
  localparam int DW    = 32;
  localparam int OCC_W = 7;
  localparam int REQ_W = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TAKE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STEAL = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  typedef struct packed {
    logic          ok;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] addr;
    logic [PW-1:0] occ;
  } op_t;

endpackage

// ----- sv/wsd_ram.sv -----
`timescale 1ns / 1ps

module wsd_ram #(
  parameter int DW = 32,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data
);

  localparam int NWORDS = 1 << AW;

  logic [DW-1:0] mem [NWORDS];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/wsd_ptr.sv -----
`timescale 1ns / 1ps

module wsd_ptr (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_en,
  input  logic [wsd_pkg::REQ_W-1:0] req_type,
  output wsd_pkg::op_t              op
);

  logic [wsd_pkg::PW-1:0] bottom_r, bottom_nxt;
  logic [wsd_pkg::PW-1:0] top_r, top_nxt;
  logic [wsd_pkg::PW-1:0] cnt;
  logic [wsd_pkg::PW-1:0] pos;
  logic [wsd_pkg::PW-1:0] top_inc;
  logic                   empty;
  logic                   full;

  assign cnt     = bottom_r - top_r;
  assign pos     = bottom_r - wsd_pkg::PW'(1);
  assign top_inc = top_r + wsd_pkg::PW'(1);
  assign empty   = (cnt == '0);
  assign full    = (cnt == wsd_pkg::PW'(wsd_pkg::DEPTH));

  always_comb begin
    bottom_nxt = bottom_r;
    top_nxt    = top_r;
    op.ok      = 1'b0;
    op.rd_en   = 1'b0;
    op.wr_en   = 1'b0;
    op.addr    = bottom_r[wsd_pkg::AW-1:0];
    unique case (req_type)
      wsd_pkg::REQ_PUSH: begin
        if (!full) begin
          op.ok      = 1'b1;
          op.wr_en   = req_en;
          bottom_nxt = bottom_r + wsd_pkg::PW'(1);
        end
      end
      wsd_pkg::REQ_TAKE: begin
        op.addr = pos[wsd_pkg::AW-1:0];
        if (!empty) begin
          op.ok    = 1'b1;
          op.rd_en = req_en;
          // last word: both ends step past it
          if (cnt == wsd_pkg::PW'(1)) begin
            top_nxt    = top_inc;
            bottom_nxt = top_inc;
          end else begin
            bottom_nxt = pos;
          end
        end
      end
      wsd_pkg::REQ_STEAL: begin
        op.addr = top_r[wsd_pkg::AW-1:0];
        if (!empty) begin
          op.ok    = 1'b1;
          op.rd_en = req_en;
          top_nxt  = top_inc;
        end
      end
      default: begin
      end
    endcase
    op.occ = bottom_nxt - top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_r <= '0;
      top_r    <= '0;
    end else if (req_en) begin
      bottom_r <= bottom_nxt;
      top_r    <= top_nxt;
    end
  end

endmodule

// ----- sv/work_stealing_deque_unit.sv -----
`timescale 1ns / 1ps

// Double-ended work queue of 64 words: push and take work at the bottom end,
// steal works at the top end. One request is accepted per cycle while the output
// is not stalled: the end pointers update and the slot memory reads the removed
// word as the request is taken, a result stage keeps its status, and an output
// register holds the result until it is taken. A push to a full queue and a take
// or steal from an empty one report failure and change nothing. An unused
// request code reports failure and the current count. Slots need no clearing
// after reset, only words that were pushed are ever read back.
module work_stealing_deque_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // push_value
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // success, removed_value, occupancy
);

  wsd_pkg::op_t op;

  logic                   in_acc;
  logic                   s1_adv;
  logic                   s1_valid_r;
  logic                   s1_ok_r;
  logic                   s1_rm_r;
  logic [wsd_pkg::PW-1:0] s1_occ_r;
  logic [wsd_pkg::DW-1:0] rd_data;

  logic                      out_tvalid_r;
  logic                      out_ok_r;
  logic [wsd_pkg::DW-1:0]    out_val_r;
  logic [wsd_pkg::OCC_W-1:0] out_occ_r;

  assign s1_adv    = s1_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  wsd_ptr u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_en   (in_acc),
    .req_type (in_tuser),
    .op       (op)
  );

  wsd_ram #(
    .DW (wsd_pkg::DW),
    .AW (wsd_pkg::AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (op.wr_en),
    .rd_en   (op.rd_en),
    .addr    (op.addr),
    .wr_data (in_tdata),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ok_r  <= op.ok;
      s1_rm_r  <= op.rd_en;
      s1_occ_r <= op.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s1_adv) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ok_r  <= s1_ok_r;
      out_val_r <= s1_rm_r ? rd_data : '0;
      out_occ_r <= wsd_pkg::OCC_W'(s1_occ_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_occ_r, out_val_r, out_ok_r};

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:33] <= 7'(wsd_pkg::DEPTH)))
    else $error("occupancy above depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[32:1] == '0))
    else $error("failed request carries a word");

  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(op.wr_en && op.rd_en))
    else $error("slot read and write in one cycle");

  a_rd_follows: assert property (@(posedge clk) disable iff (!rst_n)
    op.rd_en |=> (s1_valid_r && s1_rm_r))
    else $error("slot read without pending result");
`endif

endmodule

// ----- dv/wsd_deque_monitor.sv -----
`timescale 1ns / 1ps

module wsd_deque_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // push_value
  input  logic [1:0]  in_tuser,   // req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // success, removed_value, occupancy
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic                      success;
    logic [wsd_pkg::DW-1:0]    removed;
    logic [wsd_pkg::OCC_W-1:0] occupancy;
  } deque_result_t;

  logic [wsd_pkg::DW-1:0] slot_words [wsd_pkg::DEPTH];
  logic [wsd_pkg::PW-1:0] bottom_ptr;
  logic [wsd_pkg::PW-1:0] top_ptr;
  deque_result_t expected_q [$];

  function automatic deque_result_t serve_request(logic [wsd_pkg::REQ_W-1:0] req,
                                                  logic [wsd_pkg::DW-1:0] word);
    deque_result_t r;
    logic [wsd_pkg::PW-1:0] held;
    logic [wsd_pkg::PW-1:0] prev;
    r    = '0;
    held = bottom_ptr - top_ptr;
    prev = bottom_ptr - 1'b1;
    case (req)
      wsd_pkg::REQ_PUSH: begin
        if (held < wsd_pkg::DEPTH) begin
          slot_words[bottom_ptr[wsd_pkg::AW-1:0]] = word;
          bottom_ptr = bottom_ptr + 1'b1;
          r.success = 1'b1;
        end
      end
      wsd_pkg::REQ_TAKE: begin
        if (held != 0) begin
          r.removed = slot_words[prev[wsd_pkg::AW-1:0]];
          r.success = 1'b1;
          // last word: both ends step past it
          if (held == 1) begin
            top_ptr    = top_ptr + 1'b1;
            bottom_ptr = top_ptr;
          end else begin
            bottom_ptr = prev;
          end
        end
      end
      wsd_pkg::REQ_STEAL: begin
        if (held != 0) begin
          r.removed = slot_words[top_ptr[wsd_pkg::AW-1:0]];
          top_ptr   = top_ptr + 1'b1;
          r.success = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = bottom_ptr - top_ptr;
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      bottom_ptr = '0;
      top_ptr    = '0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.success   = out_tdata[0];
        got.removed   = out_tdata[32:1];
        got.occupancy = out_tdata[39:33];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, got success %0d removed %h occupancy %0d",
                   $time, got.success, got.removed, got.occupancy);
          errs = 1;
        end else begin
          want = expected_q.pop_front();
          if (got.success !== want.success) begin
            $display("%0t: success expected %0d got %0d", $time, want.success, got.success);
            errs = 1;
          end
          if (got.removed !== want.removed) begin
            $display("%0t: removed_value expected %h got %h", $time, want.removed,
                     got.removed);
            errs = 1;
          end
          if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
                     got.occupancy);
            errs = 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_q.push_back(serve_request(in_tuser, in_tdata));
      end
    end
    fail_count <= fail_count + errs;
    pending    <= expected_q.size();
  end

endmodule

// ----- dv/work_stealing_deque_unit_tb.sv -----
`timescale 1ns / 1ps

module work_stealing_deque_unit_tb;

  localparam int IDLE_LIMIT      = 1000;
  localparam int RANDOM_REQUESTS = 1450;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = wsd_pkg::REQ_NONE;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          rx_wait     = 0;
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;

  always #5 clk = ~clk;

  work_stealing_deque_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  wsd_deque_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side stall, redrawn after every accepted result
  always @(posedge clk) begin
    int d;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      d = rx_burst ? 0 : $urandom_range(0, 7);
      rx_wait    <= d;
      out_tready <= (d == 0);
    end else if (rx_wait != 0) begin
      rx_wait    <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [wsd_pkg::DW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [wsd_pkg::REQ_W-1:0] rand_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return wsd_pkg::REQ_PUSH;
    if (pick < 70) return wsd_pkg::REQ_TAKE;
    if (pick < 95) return wsd_pkg::REQ_STEAL;
    return wsd_pkg::REQ_NONE;
  endfunction

  task automatic send_request(input logic [wsd_pkg::REQ_W-1:0] req,
                              input logic [wsd_pkg::DW-1:0] word);
    int gap;
    if ($urandom_range(0, 59) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int issued;
    int scenario;
    int len;
    issued = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty deque, unused code, extremes, final word by take and by steal
    send_request(wsd_pkg::REQ_STEAL, 32'h0000_0000);
    send_request(wsd_pkg::REQ_TAKE,  32'hffff_ffff);
    send_request(wsd_pkg::REQ_NONE,  32'h1234_5678);
    send_request(wsd_pkg::REQ_PUSH,  32'h0000_0000);
    send_request(wsd_pkg::REQ_PUSH,  32'hffff_ffff);
    send_request(wsd_pkg::REQ_PUSH,  32'haaaa_aaaa);
    send_request(wsd_pkg::REQ_PUSH,  32'h5555_5555);
    send_request(wsd_pkg::REQ_NONE,  32'hffff_ffff);
    send_request(wsd_pkg::REQ_TAKE,  32'hdead_beef);
    send_request(wsd_pkg::REQ_STEAL, 32'hffff_ffff);
    send_request(wsd_pkg::REQ_TAKE,  32'h0000_0000);
    send_request(wsd_pkg::REQ_TAKE,  32'h0000_0000);
    send_request(wsd_pkg::REQ_TAKE,  32'h0000_0000);
    send_request(wsd_pkg::REQ_STEAL, 32'h0000_0000);
    send_request(wsd_pkg::REQ_PUSH,  32'h0000_0001);
    send_request(wsd_pkg::REQ_STEAL, 32'h0000_0000);
    send_request(wsd_pkg::REQ_PUSH,  32'h8000_0000);
    send_request(wsd_pkg::REQ_PUSH,  32'h7fff_ffff);
    send_request(wsd_pkg::REQ_STEAL, 32'hcafe_f00d);
    send_request(wsd_pkg::REQ_TAKE,  32'h0000_0000);
    send_request(wsd_pkg::REQ_NONE,  32'h0000_0000);
    drain_results();

    while (issued < RANDOM_REQUESTS) begin
      scenario = $urandom_range(0, 19);
      if (scenario == 0) begin
        // overfill: pushes past full are refused
        repeat (70) send_request(wsd_pkg::REQ_PUSH, rand_word());
        issued += 70;
      end else if (scenario == 1) begin
        // overdrain from both ends
        repeat (70) send_request($urandom_range(0, 1) ? wsd_pkg::REQ_TAKE
                                                      : wsd_pkg::REQ_STEAL, $urandom);
        issued += 70;
      end else if (scenario == 2) begin
        drain_results();
      end else begin
        len = $urandom_range(1, 24);
        repeat (len) send_request(rand_request(), rand_word());
        issued += len;
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/wsd_pkg.sv
sv/wsd_ram.sv
sv/wsd_ptr.sv
sv/work_stealing_deque_unit.sv
dv/wsd_deque_monitor.sv
dv/work_stealing_deque_unit_tb.sv
